FILE: rtl/core/cart_pole_euler_step_defines.svh
// Assertion macros shared by the cart-pole plant model RTL.
`ifndef CART_POLE_EULER_STEP_DEFINES_SVH
`define CART_POLE_EULER_STEP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cpe_pkg.sv
// Package with the constants, types and helpers of the cart-pole plant model.
`timescale 1ns / 1ps
package cpe_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicCntW  = $clog2(CordicSteps + 1);

  localparam logic signed [31:0] QMax     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin     = 32'sh8000_0000;
  localparam logic signed [31:0] GAcc     = -32'sd642908;
  localparam logic signed [31:0] TwoPiQ   = 32'sd411775;
  localparam logic signed [31:0] PiQ      = 32'sd205887;
  localparam logic signed [31:0] HalfPiQ  = 32'sd102944;
  localparam logic signed [33:0] CordGain = 34'sd652032874;

  localparam logic [0:0] FuncStep = 1'b0;
  localparam logic [0:0] FuncLoad = 1'b1;

  localparam logic [1:0] RegMass   = 2'd0;
  localparam logic [1:0] RegCart   = 2'd1;
  localparam logic [1:0] RegLength = 2'd2;
  localparam logic [1:0] RegDamp   = 2'd3;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic clip;
  } alu_sts_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0: r = 30'd843314856;  5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043836;  5'd3: r = 30'd133525158;
      5'd4: r = 30'd67021686;   5'd5: r = 30'd33543515;
      5'd6: r = 30'd16775850;   5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194282;    5'd9: r = 30'd2097149;
      5'd10: r = 30'd1048575;   5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;    5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;     5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;     5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;      5'd21: r = 30'd511;
      5'd22: r = 30'd255;       5'd23: r = 30'd127;
      5'd24: r = 30'd63;        5'd25: r = 30'd31;
      5'd26: r = 30'd15;        5'd27: r = 30'd8;
      5'd28: r = 30'd4;         5'd29: r = 30'd2;
      5'd30: r = 30'd1;         default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cart_pole_euler_step.sv
// Top level of the cart-pole plant model with one forward Euler step per step beat.
`timescale 1ns / 1ps
`include "cart_pole_euler_step_defines.svh"
// A step beat (func 0) advances cart position, cart velocity, pole angle and
// pole rate by one forward Euler step of length step_time under force_req; a
// load beat (func 1) writes the four values directly. Every accepted beat
// returns one result beat with the four values after it and a saturated flag.
// All arithmetic is signed Q16.16 with saturation. A load presents its result
// beat in the cycle after it is accepted. A step first range reduces the angle
// by one restoring subtract of a shifted 2*pi per cycle, takes sine and cosine
// from CordicSteps shared-adder rotations, then runs 31 operations one after
// another on one shared arithmetic unit. An add or subtract there passes
// through a result register, a multiply through a product register and the
// result register, and each of the two divides through a restoring loop over
// 48 quotient bits. The input is not ready while an item is in work; the
// result register frees it once the result beat is taken. Configuration writes
// are taken at any time and must only be issued while the block is idle.
module cart_pole_euler_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: force_req[31:0], step_time[47:32], load_position[79:48],
  // load_velocity[111:80], load_angle[143:112], load_rate[175:144].
  input  logic [175:0] s_axis_tdata,
  // tuser: func.
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: position_out, velocity_out, angle_out, rate_out.
  output logic [127:0] m_axis_tdata,
  // tuser: saturated.
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRed   = 4'd1;
  localparam logic [3:0] SFold  = 4'd2;
  localparam logic [3:0] SCord  = 4'd3;
  localparam logic [3:0] STrig  = 4'd4;
  localparam logic [3:0] SIssue = 4'd5;
  localparam logic [3:0] SWait  = 4'd6;
  localparam logic [3:0] SOut   = 4'd7;

  localparam int unsigned NumOps = 31;
  // Scratch slot numbers: operands come from these registers.
  localparam logic [4:0] RX = 5'd0,  RV = 5'd1,  RT = 5'd2,  RW = 5'd3;
  localparam logic [4:0] RS = 5'd4,  RC = 5'd5,  RU = 5'd6,  RH = 5'd7;
  localparam logic [4:0] Rm = 5'd8,  RM = 5'd9,  RL = 5'd10, Rd = 5'd11;
  localparam logic [4:0] RG = 5'd12, T0 = 5'd13, T1 = 5'd14, T2 = 5'd15;
  localparam logic [4:0] RK = 5'd16, RWW = 5'd17, T3 = 5'd18, RAX = 5'd19;
  localparam logic [4:0] RAW = 5'd20, NX = 5'd21, NV = 5'd22, NT = 5'd23;
  localparam logic [4:0] NW = 5'd24;
  localparam int unsigned NumRegs = 25;

  typedef struct packed {
    cpe_pkg::alu_op_e op;
    logic [4:0]       a;
    logic [4:0]       b;
    logic [4:0]       dst;
  } micro_t;

  // Program for one Euler step, evaluated in the order of the equations.
  function automatic micro_t prog(input logic [4:0] pc);
    micro_t r;
    case (pc)
      5'd0:  r = '{cpe_pkg::OpMul, RS, RS, T0};
      5'd1:  r = '{cpe_pkg::OpMul, Rm, T0, T0};
      5'd2:  r = '{cpe_pkg::OpAdd, RM, T0, RK};
      5'd3:  r = '{cpe_pkg::OpMul, Rm, RL, T0};
      5'd4:  r = '{cpe_pkg::OpMul, RW, RW, T1};
      5'd5:  r = '{cpe_pkg::OpMul, T0, T1, T0};
      5'd6:  r = '{cpe_pkg::OpMul, T0, RS, T0};
      5'd7:  r = '{cpe_pkg::OpMul, Rd, RV, T1};
      5'd8:  r = '{cpe_pkg::OpSub, T0, T1, RWW};
      5'd9:  r = '{cpe_pkg::OpAdd, RU, RWW, T0};
      5'd10: r = '{cpe_pkg::OpMul, Rm, RG, T1};
      5'd11: r = '{cpe_pkg::OpMul, T1, RC, T1};
      5'd12: r = '{cpe_pkg::OpMul, T1, RS, T1};
      5'd13: r = '{cpe_pkg::OpSub, T0, T1, T0};
      5'd14: r = '{cpe_pkg::OpDiv, T0, RK, RAX};
      5'd15: r = '{cpe_pkg::OpAdd, Rm, RM, T0};
      5'd16: r = '{cpe_pkg::OpMul, T0, RG, T0};
      5'd17: r = '{cpe_pkg::OpMul, T0, RS, T0};
      5'd18: r = '{cpe_pkg::OpAdd, RWW, RU, T1};
      5'd19: r = '{cpe_pkg::OpMul, RC, T1, T1};
      5'd20: r = '{cpe_pkg::OpSub, T0, T1, T0};
      5'd21: r = '{cpe_pkg::OpMul, RL, RK, T2};
      5'd22: r = '{cpe_pkg::OpDiv, T0, T2, RAW};
      5'd23: r = '{cpe_pkg::OpMul, RV, RH, T3};
      5'd24: r = '{cpe_pkg::OpAdd, RX, T3, NX};
      5'd25: r = '{cpe_pkg::OpMul, RAX, RH, T3};
      5'd26: r = '{cpe_pkg::OpAdd, RV, T3, NV};
      5'd27: r = '{cpe_pkg::OpMul, RW, RH, T3};
      5'd28: r = '{cpe_pkg::OpAdd, RT, T3, NT};
      5'd29: r = '{cpe_pkg::OpMul, RAW, RH, T3};
      default: r = '{cpe_pkg::OpAdd, RW, T3, NW};
    endcase
    return r;
  endfunction

  logic [3:0]         state_q, state_d;
  logic [30:0]        mass_q, cart_q, len_q, damp_q;
  logic signed [31:0] pos_q, vel_q, ang_q, rate_q;
  logic signed [31:0] rf_q [NumRegs];
  logic [4:0]         pc_q, pc_d;
  logic               sat_q, sat_d;
  logic               ovalid_q;
  logic [127:0]       odata_q;
  logic               ouser_q;

  // Angle reduction and CORDIC registers.
  logic signed [32:0] red_q, red_d;     // running magnitude remainder
  logic [5:0]         rcnt_q, rcnt_d;
  logic               rneg_q, rneg_d;
  logic               negc_q, negc_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [cpe_pkg::CordicCntW-1:0] ccnt_q, ccnt_d;

  cpe_pkg::alu_ctl_t  alu_ctl;
  cpe_pkg::alu_sts_t  alu_sts;
  logic signed [31:0] alu_a, alu_b, alu_res;
  micro_t             mi;

  logic               in_acc, out_acc;
  logic signed [32:0] trial, rr;
  logic signed [33:0] sx, sy;
  logic [4:0]         sh;
  logic signed [33:0] atn;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;
  assign cfg_ready_o = 1'b1;
  assign mi = prog(pc_q);
  assign alu_a = rf_q[mi.a];
  assign alu_b = rf_q[mi.b];
  assign alu_ctl.start = (state_q == SIssue);
  assign alu_ctl.op = mi.op;

  cpe_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d = state_q; pc_d = pc_q; sat_d = sat_q;
    red_d = red_q; rcnt_d = rcnt_q; rneg_d = rneg_q; negc_d = negc_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; ccnt_d = ccnt_q;
    trial = '0; rr = '0; sx = '0; sy = '0; atn = '0;
    sh = 5'(ccnt_q);
    case (state_q)
      SIdle: begin
        if (in_acc && (s_axis_tuser == cpe_pkg::FuncStep)) begin
          // Reduce |th| modulo 2*pi by restoring subtraction of 2*pi<<k.
          // |th| is at most 2^31, so the quotient fits in 13 bits.
          rneg_d = ang_q[31];
          red_d  = ang_q[31] ? -33'(ang_q) : 33'(ang_q);
          rcnt_d = 6'd12;
          sat_d  = 1'b0;
          state_d = SRed;
        end
      end
      SRed: begin
        trial = red_q - (33'(cpe_pkg::TwoPiQ) <<< rcnt_q);
        if (trial >= 0) red_d = trial;
        rcnt_d = rcnt_q - 6'd1;
        if (rcnt_q == 6'd0) state_d = SFold;
      end
      SFold: begin
        // Floor modulo: a negative angle with nonzero remainder wraps.
        rr = (rneg_q && red_q != 0) ? (33'(cpe_pkg::TwoPiQ) - red_q) : red_q;
        if (rr > 33'(cpe_pkg::PiQ)) rr = rr - 33'(cpe_pkg::TwoPiQ);
        negc_d = 1'b0;
        if (rr > 33'(cpe_pkg::HalfPiQ)) begin
          rr = 33'(cpe_pkg::PiQ) - rr; negc_d = 1'b1;
        end else if (rr < -33'(cpe_pkg::HalfPiQ)) begin
          rr = -33'(cpe_pkg::PiQ) - rr; negc_d = 1'b1;
        end
        cz_d = 34'(rr) <<< 14;
        cx_d = cpe_pkg::CordGain;
        cy_d = '0;
        ccnt_d = '0;
        state_d = SCord;
      end
      SCord: begin
        sx = cx_q >>> sh;
        sy = cy_q >>> sh;
        atn = 34'(cpe_pkg::atan_q30(sh));
        if (!cz_q[33]) begin
          cx_d = cx_q - sy; cy_d = cy_q + sx; cz_d = cz_q - atn;
        end else begin
          cx_d = cx_q + sy; cy_d = cy_q - sx; cz_d = cz_q + atn;
        end
        ccnt_d = ccnt_q + 1'b1;
        if (ccnt_q == cpe_pkg::CordicCntW'(cpe_pkg::CordicSteps - 1)) state_d = STrig;
      end
      STrig: begin
        pc_d = '0;
        state_d = SIssue;
      end
      SIssue: state_d = SWait;
      SWait: begin
        if (alu_sts.done) begin
          sat_d = sat_q | alu_sts.clip;
          if (pc_q == 5'(NumOps - 1)) begin
            state_d = SOut;
          end else begin
            pc_d = pc_q + 5'd1;
            state_d = SIssue;
          end
        end
      end
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
      mass_q   <= 31'd65536;
      cart_q   <= 31'd327680;
      len_q    <= 31'd131072;
      damp_q   <= 31'd65536;
      pos_q    <= '0;
      vel_q    <= '0;
      ang_q    <= '0;
      rate_q   <= '0;
      pc_q     <= '0;
      sat_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sat_q   <= sat_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cpe_pkg::RegMass:   mass_q <= cfg_data_i;
          cpe_pkg::RegCart:   cart_q <= cfg_data_i;
          cpe_pkg::RegLength: len_q  <= cfg_data_i;
          default:            damp_q <= cfg_data_i;
        endcase
      end
      if (out_acc) ovalid_q <= 1'b0;
      if (in_acc && (s_axis_tuser == cpe_pkg::FuncLoad)) begin
        pos_q  <= s_axis_tdata[79:48];
        vel_q  <= s_axis_tdata[111:80];
        ang_q  <= s_axis_tdata[143:112];
        rate_q <= s_axis_tdata[175:144];
        odata_q  <= s_axis_tdata[175:48];
        ouser_q  <= 1'b0;
        ovalid_q <= 1'b1;
      end
      if (state_q == SOut) begin
        pos_q  <= rf_q[NX];
        vel_q  <= rf_q[NV];
        ang_q  <= rf_q[NT];
        rate_q <= rf_q[NW];
        odata_q  <= {rf_q[NW], rf_q[NT], rf_q[NV], rf_q[NX]};
        ouser_q  <= sat_q;
        ovalid_q <= 1'b1;
      end
    end
  end

  // Scratch registers of the step program.
  always_ff @(posedge clk_i) begin
    red_q <= red_d; rcnt_q <= rcnt_d; rneg_q <= rneg_d; negc_q <= negc_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; ccnt_q <= ccnt_d;
    if (state_q == STrig) begin
      rf_q[RX] <= pos_q;  rf_q[RV] <= vel_q;
      rf_q[RT] <= ang_q;  rf_q[RW] <= rate_q;
      rf_q[RS] <= 32'(cy_q >>> 14);
      rf_q[RC] <= negc_q ? 32'(-(cx_q >>> 14)) : 32'(cx_q >>> 14);
      rf_q[Rm] <= {1'b0, mass_q}; rf_q[RM] <= {1'b0, cart_q};
      rf_q[RL] <= {1'b0, len_q};  rf_q[Rd] <= {1'b0, damp_q};
      rf_q[RG] <= cpe_pkg::GAcc;
    end
    if (state_q == SIdle && in_acc) begin
      rf_q[RU] <= s_axis_tdata[31:0];
      rf_q[RH] <= {16'd0, s_axis_tdata[47:32]};
    end
    if (state_q == SWait && alu_sts.done) rf_q[mi.dst] <= alu_res;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  `CPE_ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, state_q != SIdle, !s_axis_tready,
                   "input ready while a step is in work")
  `CPE_ASSERT_IMPL(a_out_free, clk_i, rst_ni, state_q == SOut, !ovalid_q,
                   "step result would overwrite a pending beat")
  `CPE_ASSERT_NEXT(a_pc_range, clk_i, rst_ni, state_q == SIssue, pc_q < 5'(NumOps),
                   "program counter out of range")

endmodule

FILE: rtl/core/cpe_alu.sv
// Shared Q16.16 arithmetic unit: saturating add, subtract, multiply, divide.
`timescale 1ns / 1ps
`include "cart_pole_euler_step_defines.svh"
module cpe_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpe_pkg::alu_ctl_t   ctl_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output cpe_pkg::alu_sts_t   sts_o,
  output logic signed [31:0]  res_o
);

  // Multiply goes through a product register, then shift and clip.
  // Divide is restoring, one quotient bit per cycle over 48 bits.
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SDiv  = 3'd2;
  localparam logic [2:0] SDone = 3'd3;
  localparam logic [2:0] SDivF = 3'd4;

  logic [2:0]         state_q, state_d;
  logic signed [63:0] prod_q, prod_d;
  logic [47:0]        num_q, num_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        den_q, den_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               nneg_q, nneg_d, dneg_q, dneg_d, nz_q, nz_d;
  logic signed [31:0] res_q, res_d;
  logic               clip_q, clip_d;

  logic signed [32:0] sum;
  logic signed [47:0] shr;
  logic [32:0]        trial;
  logic [48:0]        qmag;

  always_comb begin
    state_d = state_q; prod_d = prod_q; num_d = num_q; rem_d = rem_q;
    den_d = den_q; cnt_d = cnt_q; nneg_d = nneg_q; dneg_d = dneg_q;
    nz_d = nz_q; res_d = res_q; clip_d = clip_q;
    sum = '0; shr = '0; trial = '0; qmag = '0;
    case (state_q)
      SIdle: begin
        if (ctl_i.start) begin
          clip_d = 1'b0;
          case (ctl_i.op)
            cpe_pkg::OpAdd, cpe_pkg::OpSub: begin
              sum = (ctl_i.op == cpe_pkg::OpAdd) ? (33'(a_i) + 33'(b_i))
                                                  : (33'(a_i) - 33'(b_i));
              if (sum > 33'sd2147483647) begin
                res_d = cpe_pkg::QMax; clip_d = 1'b1;
              end else if (sum < -33'sd2147483648) begin
                res_d = cpe_pkg::QMin; clip_d = 1'b1;
              end else begin
                res_d = sum[31:0];
              end
              state_d = SDone;
            end
            cpe_pkg::OpMul: begin
              prod_d  = 64'(a_i) * 64'(b_i);
              state_d = SMul;
            end
            default: begin
              nneg_d = a_i[31];
              dneg_d = b_i[31];
              nz_d   = (a_i != 32'sd0);
              num_d  = {(a_i[31] ? 32'(-33'(a_i)) : a_i), 16'd0};
              den_d  = b_i[31] ? 32'(-33'(b_i)) : b_i;
              rem_d  = '0;
              cnt_d  = 6'd48;
              state_d = (b_i == 32'sd0) ? SDivF : SDiv;
            end
          endcase
        end
      end
      SMul: begin
        shr = prod_q[63:16];
        if (shr > 48'sd2147483647) begin
          res_d = cpe_pkg::QMax; clip_d = 1'b1;
        end else if (shr < -48'sd2147483648) begin
          res_d = cpe_pkg::QMin; clip_d = 1'b1;
        end else begin
          res_d = shr[31:0];
        end
        state_d = SDone;
      end
      SDiv: begin
        trial = {rem_q[31:0], num_q[47]};
        num_d = {num_q[46:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          num_d[0] = 1'b1;
        end else begin
          rem_d = trial;
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = SDivF;
      end
      SDivF: begin
        if (den_q == 32'd0) begin
          clip_d = nz_q;
          res_d  = !nz_q ? 32'sd0 : (nneg_q ? cpe_pkg::QMin : cpe_pkg::QMax);
        end else begin
          qmag = {1'b0, num_q};
          if (nneg_q ^ dneg_q) begin
            if (qmag > 49'd2147483648) begin
              res_d = cpe_pkg::QMin; clip_d = 1'b1;
            end else begin
              res_d = 32'(-qmag);
            end
          end else if (qmag > 49'd2147483647) begin
            res_d = cpe_pkg::QMax; clip_d = 1'b1;
          end else begin
            res_d = qmag[31:0];
          end
        end
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      clip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clip_q  <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    cnt_q <= cnt_d; nneg_q <= nneg_d; dneg_q <= dneg_d; nz_q <= nz_d;
    res_q <= res_d;
  end

  assign res_o      = res_q;
  assign sts_o.busy = (state_q != SIdle);
  assign sts_o.done = (state_q == SDone);
  assign sts_o.clip = clip_q;

  `CPE_ASSERT_IMPL(a_no_start_busy, clk_i, rst_ni, sts_o.busy, !ctl_i.start,
                   "alu started while busy")
  `CPE_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, sts_o.done, !sts_o.done,
                   "alu done held two cycles")
  `CPE_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, ctl_i.start, sts_o.busy,
                   "alu not busy after start")

endmodule

FILE: test/cart_pole_euler_step_tb.sv
// Self-checking testbench for the cart-pole Euler step plant model.
`timescale 1ns / 1ps
// The testbench feeds load and step beats through the input stream, predicts
// every result beat with its own fixed-point model of the plant, and compares
// each result field by field. It runs through several register settings,
// including the extremes, random sender bursts and gaps, a receiver stall
// pattern, and one long receiver hold-off that backs the block up.
module cart_pole_euler_step_tb;

  localparam int ClkHalf = 10;
  localparam int WatchdogLimit = 40000;
  localparam int HoldOffCycles = 3000;
  localparam int DrainCycles = 600;
  localparam longint QHi = 64'sd2147483647;
  localparam longint QLo = -64'sd2147483648;

  typedef struct {
    logic [0:0] func;
    logic signed [31:0] force_req;
    logic [15:0] step_time;
    logic signed [31:0] load_pos;
    logic signed [31:0] load_vel;
    logic signed [31:0] load_ang;
    logic signed [31:0] load_rate;
  } plant_item_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] ang;
    logic signed [31:0] rate;
    logic sat;
  } plant_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  cart_pole_euler_step uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Shadow copies of the plant registers and the plant state.
  longint mass_q = 65536, cart_q = 327680, len_q = 131072, damp_q = 65536;
  longint pos_q = 0, vel_q = 0, ang_q = 0, rate_q = 0;
  bit clip_seen;

  plant_item_t pending_items[$];
  plant_state_t expected_states[$];
  plant_item_t cur_item;
  int fail_count = 0;
  int burst_left = 0, gap_left = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int watchdog = 0;

  function automatic longint sat32(longint v);
    if (v > QHi) begin
      clip_seen = 1;
      return QHi;
    end
    if (v < QLo) begin
      clip_seen = 1;
      return QLo;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    if (d == 0) begin
      if (n == 0) return 0;
      clip_seen = 1;
      return (n > 0) ? QHi : QLo;
    end
    return sat32((n * 65536) / d);
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767};
    return tab[i];
  endfunction

  // Range reduction into (-pi, pi], quadrant fold, then CORDIC rotation.
  task automatic sine_cosine(input longint th, output longint s, output longint c);
    longint r, x, y, z, nx;
    bit neg_c;
    r = th % longint'(cpe_pkg::TwoPiQ);
    x = cpe_pkg::CordGain;
    y = 0;
    neg_c = 0;
    if (r < 0) r += cpe_pkg::TwoPiQ;
    if (r > cpe_pkg::PiQ) r -= cpe_pkg::TwoPiQ;
    if (r > cpe_pkg::HalfPiQ) begin
      r = cpe_pkg::PiQ - r;
      neg_c = 1;
    end else if (r < -longint'(cpe_pkg::HalfPiQ)) begin
      r = -longint'(cpe_pkg::PiQ) - r;
      neg_c = 1;
    end
    z = r * 16384;
    for (int i = 0; i < cpe_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_entry(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_entry(i);
      end
      x = nx;
    end
    s = y >>> 14;
    c = neg_c ? -(x >>> 14) : (x >>> 14);
  endtask

  // Advances the shadow plant by one accepted beat and queues its result.
  task automatic advance_plant(input plant_item_t it);
    longint s, c, k, w_term, ax, aw, n_x, n_w, u, h;
    plant_state_t res;
    clip_seen = 0;
    if (it.func == cpe_pkg::FuncLoad) begin
      pos_q = it.load_pos;
      vel_q = it.load_vel;
      ang_q = it.load_ang;
      rate_q = it.load_rate;
    end else begin
      u = it.force_req;
      h = it.step_time;
      sine_cosine(ang_q, s, c);
      k = sat32(cart_q + fx_mul(mass_q, fx_mul(s, s)));
      w_term = sat32(fx_mul(fx_mul(fx_mul(mass_q, len_q), fx_mul(rate_q, rate_q)), s)
                     - fx_mul(damp_q, vel_q));
      n_x = sat32(sat32(u + w_term)
                  - fx_mul(fx_mul(fx_mul(mass_q, cpe_pkg::GAcc), c), s));
      ax = fx_div(n_x, k);
      n_w = sat32(fx_mul(fx_mul(sat32(mass_q + cart_q), cpe_pkg::GAcc), s)
                  - fx_mul(c, sat32(w_term + u)));
      aw = fx_div(n_w, fx_mul(len_q, k));
      n_x = sat32(pos_q + fx_mul(vel_q, h));
      vel_q = sat32(vel_q + fx_mul(ax, h));
      n_w = sat32(ang_q + fx_mul(rate_q, h));
      rate_q = sat32(rate_q + fx_mul(aw, h));
      pos_q = n_x;
      ang_q = n_w;
    end
    res.pos = pos_q[31:0];
    res.vel = vel_q[31:0];
    res.ang = ang_q[31:0];
    res.rate = rate_q[31:0];
    res.sat = clip_seen;
    expected_states.push_back(res);
  endtask

  // Sender: bursts of beats with random gaps; data holds until accepted.
  always @(posedge clk_i) begin
    logic nv;
    nv = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      advance_plant(cur_item);
      void'(pending_items.pop_front());
      nv = 1'b0;
    end
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
        nv = 1'b0;
      end else if (pending_items.size() > 0) begin
        nv = 1'b1;
        cur_item = pending_items[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        nv = 1'b0;
      end
      s_axis_tvalid <= nv;
      if (nv) begin
        s_axis_tuser <= cur_item.func;
        s_axis_tdata <= {cur_item.load_rate, cur_item.load_ang, cur_item.load_vel,
                         cur_item.load_pos, cur_item.step_time, cur_item.force_req};
      end
    end
  end

  // Receiver: a changing stall pattern, plus one long hold-off on request.
  always @(posedge clk_i) begin
    plant_state_t e;
    plant_state_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.pos = m_axis_tdata[31:0];
      got.vel = m_axis_tdata[63:32];
      got.ang = m_axis_tdata[95:64];
      got.rate = m_axis_tdata[127:96];
      got.sat = m_axis_tuser;
      if (expected_states.size() == 0) begin
        $error("result beat with no expected result pending");
        fail_count++;
      end else begin
        e = expected_states.pop_front();
        if (got.pos !== e.pos) begin
          $error("position_out expected %0d got %0d", e.pos, got.pos);
          fail_count++;
        end
        if (got.vel !== e.vel) begin
          $error("velocity_out expected %0d got %0d", e.vel, got.vel);
          fail_count++;
        end
        if (got.ang !== e.ang) begin
          $error("angle_out expected %0d got %0d", e.ang, got.ang);
          fail_count++;
        end
        if (got.rate !== e.rate) begin
          $error("rate_out expected %0d got %0d", e.rate, got.rate);
          fail_count++;
        end
        if (got.sat !== e.sat) begin
          $error("saturated expected %0b got %0b", e.sat, got.sat);
          fail_count++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rst_ni) begin
      // The receiver mood shifts slowly: sometimes mostly ready, else spotty.
      case ((($urandom_range(0, 63) == 0) ? 1 : 0) + (m_axis_tready ? 0 : 2))
        0: m_axis_tready <= ($urandom_range(0, 9) != 0);
        1, 3: m_axis_tready <= ~m_axis_tready;
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any beat moving on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      watchdog <= 0;
    end else if (watchdog >= WatchdogLimit) begin
      $display("cart_pole_euler_step_tb failed");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  function automatic plant_item_t load_beat(longint p, longint v, longint a, longint r);
    plant_item_t it;
    it.func = cpe_pkg::FuncLoad;
    it.force_req = $urandom;
    it.step_time = $urandom;
    it.load_pos = p;
    it.load_vel = v;
    it.load_ang = a;
    it.load_rate = r;
    return it;
  endfunction

  function automatic plant_item_t step_beat(longint u, int h);
    plant_item_t it;
    it = load_beat($urandom, $urandom, $urandom, $urandom);
    it.func = cpe_pkg::FuncStep;
    it.force_req = u;
    it.step_time = h;
    return it;
  endfunction

  function automatic longint smallish(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  // Mostly a realistic load followed by a few steps, with some raw noise.
  task automatic queue_random(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back($urandom_range(0, 1) ? load_beat($urandom, $urandom,
                                $urandom, $urandom) : step_beat($urandom, $urandom));
        n++;
      end else begin
        pending_items.push_back(load_beat(smallish(22), smallish(20), smallish(20),
                                          smallish(19)));
        n++;
        repeat ($urandom_range(1, 6)) begin
          pending_items.push_back(step_beat(smallish($urandom_range(8, 26)),
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 3000)));
          n++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_states.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all four registers back to back, valid held high between beats.
  task automatic write_regs(input longint m, input longint mc, input longint l,
                            input longint d);
    logic [30:0] vals[4];
    vals = '{m[30:0], mc[30:0], l[30:0], d[30:0]};
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= cpe_pkg::RegMass;
    cfg_data_i <= vals[0];
    for (int i = 0; i < 4; i++) begin
      do @(posedge clk_i);
      while (!cfg_ready_o);
      if (i < 3) begin
        cfg_index_i <= 2'(i + 1);
        cfg_data_i <= vals[i + 1];
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
    mass_q = vals[0];
    cart_q = vals[1];
    len_q = vals[2];
    damp_q = vals[3];
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed beats under the reset register values.
    pending_items.push_back(step_beat(0, 0));
    pending_items.push_back(step_beat(QHi, 65535));
    pending_items.push_back(step_beat(QLo, 65535));
    pending_items.push_back(load_beat(0, 0, cpe_pkg::HalfPiQ, 0));
    pending_items.push_back(step_beat(65536, 6554));
    pending_items.push_back(load_beat(0, 0, -longint'(cpe_pkg::HalfPiQ) - 1, 0));
    pending_items.push_back(step_beat(-65536, 6554));
    pending_items.push_back(load_beat(0, 0, cpe_pkg::PiQ, 65536));
    pending_items.push_back(step_beat(0, 6554));
    pending_items.push_back(load_beat(0, 0, -longint'(cpe_pkg::PiQ), 0));
    pending_items.push_back(step_beat(0, 655));
    pending_items.push_back(load_beat(QHi, QHi, QHi, QHi));
    pending_items.push_back(step_beat(QHi, 65535));
    pending_items.push_back(load_beat(QLo, QLo, QLo, QLo));
    pending_items.push_back(step_beat(QLo, 65535));
    pending_items.push_back(load_beat(-1, -1, cpe_pkg::TwoPiQ, -1));
    pending_items.push_back(step_beat(-1, 1));
    pending_items.push_back(load_beat(1000, -2000, 3 * longint'(cpe_pkg::PiQ), 5 << 16));
    pending_items.push_back(step_beat(10 << 16, 3277));
    queue_random(60);
    // Long receiver hold-off while the sender keeps offering beats.
    repeat (200) @(posedge clk_i);
    hold_req = 1;
    queue_random(390);
    wait_idle();
    write_regs($urandom_range(16384, 262144), $urandom_range(65536, 1048576),
               $urandom_range(32768, 524288), $urandom_range(0, 262144));
    queue_random(450);
    wait_idle();
    write_regs(QHi, QHi, QHi, QHi);
    queue_random(200);
    wait_idle();
    write_regs(1, 1, 1, 0);
    queue_random(200);
    wait_idle();
    // Out-of-range zero masses make the divisors vanish.
    write_regs(0, 0, 0, 65536);
    queue_random(60);
    wait_idle();
    write_regs(65536, 327680, 131072, 65536);
    queue_random(440);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_states.size() == 0) begin
      $display("cart_pole_euler_step_tb passed");
    end else begin
      $display("cart_pole_euler_step_tb failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cpe_pkg.sv
rtl/core/cpe_alu.sv
rtl/core/cart_pole_euler_step.sv
test/cart_pole_euler_step_tb.sv
